>>> rtl/core/touch_gesture_tracker_defines.svh
// Assertion macros shared by the touch gesture tracker RTL.
`ifndef TOUCH_GESTURE_TRACKER_DEFINES_SVH
`define TOUCH_GESTURE_TRACKER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TGT_ASSERT_IMPLY(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define TGT_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/core/tgt_pkg.sv
// Shared types and constants of the touch gesture tracker.
`default_nettype none
package tgt_pkg;

   localparam int RAW_W      = 12;
   localparam int PIX_W      = 10;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 12;

   localparam logic [CSR_IDX_W-1:0] CSR_CAL_START_X   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CAL_END_X     = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_CAL_START_Y   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_CAL_END_Y     = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_SCREEN_WIDTH  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_SCREEN_HEIGHT = 3'd5;

   localparam logic [RAW_W-1:0] CAL_START_RESET   = 12'd200;
   localparam logic [RAW_W-1:0] CAL_END_RESET     = 12'd3900;
   localparam logic [PIX_W-1:0] SCREEN_W_RESET    = 10'd240;
   localparam logic [PIX_W-1:0] SCREEN_H_RESET    = 10'd320;

   typedef enum logic [1:0] {
      EV_START    = 2'd0,
      EV_TOUCHING = 2'd1,
      EV_CLICK    = 2'd2,
      EV_RELEASE  = 2'd3
   } event_type;

   typedef enum logic [2:0] {
      CS_NONE     = 3'b001,
      CS_START    = 3'b010,
      CS_TOUCHING = 3'b100
   } click_type;

   typedef enum logic [6:0] {
      ST_IDLE  = 7'b0000001,
      ST_SUM   = 7'b0000010,
      ST_LOAD  = 7'b0000100,
      ST_WAIT  = 7'b0001000,
      ST_CLAMP = 7'b0010000,
      ST_MUL   = 7'b0100000,
      ST_EMIT  = 7'b1000000
   } state_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_stat_type;

endpackage
`default_nettype wire

>>> rtl/core/tgt_divider.sv
// Serial restoring divider, one quotient bit per cycle.
`default_nettype none
module tgt_divider
   import tgt_pkg::*;
#(
   parameter int NUM_W = 22,
   parameter int DEN_W = 12
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire logic [NUM_W-1:0] dividend,
   input  wire logic [DEN_W-1:0] divisor,
   output div_stat_type          stat,
   output logic      [NUM_W-1:0] quotient
);

   localparam int CNT_W = $clog2(NUM_W + 1);

   logic [NUM_W-1:0] quo_ff, quo_in;
   logic [DEN_W-1:0] rem_ff, rem_in;
   logic [DEN_W-1:0] den_ff, den_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [DEN_W:0]   shifted;
   logic [DEN_W+1:0] diff;
   logic             borrow;

   // Bring down the next dividend bit and try to subtract the divisor.
   assign shifted = {rem_ff, quo_ff[NUM_W-1]};
   assign diff    = {1'b0, shifted} - {2'b00, den_ff};
   assign borrow  = diff[DEN_W+1];

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         den_in  = divisor;
         cnt_in  = CNT_W'(NUM_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         quo_in = {quo_ff[NUM_W-2:0], ~borrow};
         rem_in = borrow ? shifted[DEN_W-1:0] : diff[DEN_W-1:0];
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign quotient  = quo_ff;

endmodule
`default_nettype wire

>>> rtl/core/touch_gesture_tracker.sv
// Touch gesture tracker top level: tick checks, gesture state and position scaling.
//
// Usage: one panel sample is one beat on the req_ channel (req_valid/req_stall).
// Every TICKS_PER_CHECK beats the block checks whether all of them were touched
// and may produce one result beat on the rsp_ channel: touch start, touching
// (with scaled screen position), single click or release (with the last screen
// position). The csr_ port writes calibration and screen size; the user must
// write them only while idle, as the block itself does not enforce it.
// Steps: a beat that gives no result is only accepted; a beat that gives
// start, click or release is accepted, then its result is loaded into the
// output register. A beat that completes a position average first sums the
// AVERAGE_DEPTH stored samples, then per axis computes the average, clamps
// it, multiplies and runs a NUM_W-step division on the shared serial divider,
// the x axis before the y axis, before its result is loaded.
// req_stall is high while an item is being worked on.
// Reset is synchronous and clears the gesture state, the last screen position
// and the output valid, and restores the default calibration.
// When the receiver stalls, the result beat stays in the output register; the
// block still accepts the next sample and, once that sample has a result of its
// own ready, waits in the emit state while the output register is still full.
`default_nettype none
`include "touch_gesture_tracker_defines.svh"
module touch_gesture_tracker
   import tgt_pkg::*;
#(
   parameter int TICKS_PER_CHECK = 2,
   parameter int AVERAGE_DEPTH   = 2,
   parameter int CLICK_CHECKS    = 4
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire logic                  req_touched,
   input  wire logic [RAW_W-1:0]      req_raw_x,
   input  wire logic [RAW_W-1:0]      req_raw_y,
   input  wire logic                  req_pos_ok,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output logic [1:0]                 rsp_event_code,
   output logic [PIX_W-1:0]           rsp_screen_x,
   output logic [PIX_W-1:0]           rsp_screen_y,
   input  wire logic                  csr_we,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int PHASE_W = (TICKS_PER_CHECK > 1) ? $clog2(TICKS_PER_CHECK) : 1;
   localparam int IDX_W   = (AVERAGE_DEPTH > 1) ? $clog2(AVERAGE_DEPTH) : 1;
   localparam int HOLD_W  = $clog2(CLICK_CHECKS + 2);
   localparam int SUM_W   = RAW_W + $clog2(AVERAGE_DEPTH + 1);
   localparam int PROD_W  = PIX_W + RAW_W;
   localparam int NUM_W   = (PROD_W > SUM_W) ? PROD_W : SUM_W;

   // The average divides by a constant: multiply by the rounded-up reciprocal
   // and shift, which is exact for every sum that fits in SUM_W bits.
   localparam int AVG_SHIFT = SUM_W + $clog2(AVERAGE_DEPTH);
   localparam int AVG_PW    = 2 * SUM_W + 1;
   localparam logic [SUM_W:0] AVG_RECIP =
      (SUM_W + 1)'(((1 << AVG_SHIFT) + AVERAGE_DEPTH - 1) / AVERAGE_DEPTH);

   localparam logic [PHASE_W-1:0] PHASE_LAST = PHASE_W'(TICKS_PER_CHECK - 1);
   localparam logic [IDX_W-1:0]   IDX_LAST   = IDX_W'(AVERAGE_DEPTH - 1);
   localparam logic [HOLD_W-1:0]  HOLD_LIM   = HOLD_W'(CLICK_CHECKS);
   localparam logic [HOLD_W-1:0]  HOLD_SAT   = HOLD_W'(CLICK_CHECKS + 1);

   // Configuration registers.
   logic [RAW_W-1:0] cal_start_x_ff, cal_end_x_ff, cal_start_y_ff, cal_end_y_ff;
   logic [PIX_W-1:0] screen_w_ff, screen_h_ff;

   // Gesture state.
   state_type         state_ff, state_in;
   logic [PHASE_W-1:0] phase_ff, phase_in;
   logic              all_ff, all_in;
   click_type         click_ff, click_in;
   logic [HOLD_W-1:0] hold_ff, hold_in;
   logic [IDX_W-1:0]  idx_ff, idx_in;
   logic [RAW_W-1:0]  store_x_ff [AVERAGE_DEPTH];
   logic [RAW_W-1:0]  store_y_ff [AVERAGE_DEPTH];
   logic [PIX_W-1:0]  last_x_ff, last_x_in;
   logic [PIX_W-1:0]  last_y_ff, last_y_in;

   // Sequencer working registers.
   event_type         pend_code_ff, pend_code_in;
   logic [IDX_W-1:0]  k_ff, k_in;
   logic [SUM_W-1:0]  sum_x_ff, sum_x_in, sum_y_ff, sum_y_in;
   logic              axis_ff, axis_in;
   logic              scale_ff, scale_in;
   logic [RAW_W-1:0]  avg_ff, avg_in;
   logic [RAW_W-1:0]  off_ff, off_in;
   logic [PROD_W-1:0] prod_ff, prod_in;

   // Output register.
   logic              rsp_valid_ff, rsp_valid_in;
   event_type         rsp_code_ff, rsp_code_in;
   logic [PIX_W-1:0]  rsp_x_ff, rsp_x_in, rsp_y_ff, rsp_y_in;

   // Check decode.
   logic              req_acc, is_check, all_now, store_we, emit_now, run_avg;
   event_type         emit_code;
   logic              rsp_free;

   // Per-axis operands and the shared divider.
   logic [SUM_W-1:0]  sel_sum;
   logic [AVG_PW-1:0] avg_prod;
   logic [RAW_W-1:0]  avg_now;
   logic [RAW_W-1:0]  sel_start, sel_end, span;
   logic [PIX_W-1:0]  sel_size;
   logic              span_zero;
   logic [RAW_W-1:0]  off_raw;
   logic [PIX_W-1:0]  pixel;
   logic              div_start;
   logic [NUM_W-1:0]  div_num, div_quo;
   logic [RAW_W-1:0]  div_den;
   div_stat_type      div_stat;

   assign req_acc  = req_valid && (state_ff == ST_IDLE);
   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_free = !rsp_valid_ff || !rsp_stall;

   // Configuration writes; unknown indexes are ignored.
   always_ff @(posedge clock) begin
      if (reset) begin
         cal_start_x_ff <= CAL_START_RESET;
         cal_end_x_ff   <= CAL_END_RESET;
         cal_start_y_ff <= CAL_START_RESET;
         cal_end_y_ff   <= CAL_END_RESET;
         screen_w_ff    <= SCREEN_W_RESET;
         screen_h_ff    <= SCREEN_H_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_CAL_START_X:   cal_start_x_ff <= csr_wdata[RAW_W-1:0];
            CSR_CAL_END_X:     cal_end_x_ff   <= csr_wdata[RAW_W-1:0];
            CSR_CAL_START_Y:   cal_start_y_ff <= csr_wdata[RAW_W-1:0];
            CSR_CAL_END_Y:     cal_end_y_ff   <= csr_wdata[RAW_W-1:0];
            CSR_SCREEN_WIDTH:  screen_w_ff    <= csr_wdata[PIX_W-1:0];
            CSR_SCREEN_HEIGHT: screen_h_ff    <= csr_wdata[PIX_W-1:0];
            default: ;
         endcase
      end
   end

   // Tick collection and the touch check. A check is confirmed only when every
   // tick since the previous check was touched.
   assign is_check = (phase_ff == PHASE_LAST);
   assign all_now  = all_ff & req_touched;

   always_comb begin
      phase_in  = phase_ff;
      all_in    = all_ff;
      click_in  = click_ff;
      hold_in   = hold_ff;
      idx_in    = idx_ff;
      store_we  = 1'b0;
      emit_now  = 1'b0;
      emit_code = EV_START;
      run_avg   = 1'b0;
      if (req_acc) begin
         if (!is_check) begin
            phase_in = phase_ff + PHASE_W'(1);
            all_in   = all_now;
         end else begin
            phase_in = '0;
            all_in   = 1'b1;
            if (all_now) begin
               if (click_ff == CS_NONE) begin
                  click_in  = CS_START;
                  emit_now  = 1'b1;
                  emit_code = EV_START;
               end
               if (hold_ff < HOLD_LIM) begin
                  hold_in = hold_ff + HOLD_W'(1);
               end else begin
                  // Held long enough: the touch is a drag, positions count now.
                  hold_in  = HOLD_SAT;
                  click_in = CS_TOUCHING;
                  if (req_pos_ok) begin
                     store_we = 1'b1;
                     if (idx_ff == IDX_LAST) begin
                        idx_in  = '0;
                        run_avg = 1'b1;
                     end else begin
                        idx_in = idx_ff + IDX_W'(1);
                     end
                  end
               end
            end else begin
               // Released: a short press is a click, a drag ends in release.
               if ((click_ff == CS_START) && (hold_ff <= HOLD_LIM)) begin
                  emit_now  = 1'b1;
                  emit_code = EV_CLICK;
               end else if (click_ff == CS_TOUCHING) begin
                  emit_now  = 1'b1;
                  emit_code = EV_RELEASE;
               end
               hold_in  = '0;
               click_in = CS_NONE;
               idx_in   = '0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (store_we) begin
         store_x_ff[idx_ff] <= req_raw_x;
         store_y_ff[idx_ff] <= req_raw_y;
      end
   end

   // Axis operand selection. An empty calibration window gives span zero.
   assign sel_sum   = axis_ff ? sum_y_ff : sum_x_ff;
   assign sel_start = axis_ff ? cal_start_y_ff : cal_start_x_ff;
   assign sel_end   = axis_ff ? cal_end_y_ff : cal_end_x_ff;
   assign sel_size  = axis_ff ? screen_h_ff : screen_w_ff;
   assign span_zero = !(sel_end > sel_start);
   assign span      = span_zero ? '0 : sel_end - sel_start;
   assign off_raw   = (avg_ff > sel_start) ? avg_ff - sel_start : '0;
   assign pixel     = span_zero ? '0 : div_quo[PIX_W-1:0];

   assign avg_prod = AVG_PW'(sel_sum) * AVG_PW'(AVG_RECIP);
   assign avg_now  = avg_prod[AVG_SHIFT +: RAW_W];

   // The shared divider scales the clamped product by the window span.
   assign div_num = NUM_W'(prod_ff);
   assign div_den = span;

   tgt_divider #(
      .NUM_W (NUM_W),
      .DEN_W (RAW_W)
   ) u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_num),
      .divisor  (div_den),
      .stat     (div_stat),
      .quotient (div_quo)
   );

   // Sequencer.
   always_comb begin
      state_in     = state_ff;
      pend_code_in = pend_code_ff;
      k_in         = k_ff;
      sum_x_in     = sum_x_ff;
      sum_y_in     = sum_y_ff;
      axis_in      = axis_ff;
      scale_in     = scale_ff;
      avg_in       = avg_ff;
      off_in       = off_ff;
      prod_in      = prod_ff;
      last_x_in    = last_x_ff;
      last_y_in    = last_y_ff;
      div_start    = 1'b0;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_code_in  = rsp_code_ff;
      rsp_x_in     = rsp_x_ff;
      rsp_y_in     = rsp_y_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               if (run_avg) begin
                  pend_code_in = emit_now ? emit_code : EV_TOUCHING;
                  k_in         = '0;
                  sum_x_in     = '0;
                  sum_y_in     = '0;
                  axis_in      = 1'b0;
                  scale_in     = 1'b0;
                  state_in     = ST_SUM;
               end else if (emit_now) begin
                  pend_code_in = emit_code;
                  state_in     = ST_EMIT;
               end
            end
         end
         ST_SUM: begin
            sum_x_in = sum_x_ff + SUM_W'(store_x_ff[k_ff]);
            sum_y_in = sum_y_ff + SUM_W'(store_y_ff[k_ff]);
            k_in     = k_ff + IDX_W'(1);
            if (k_ff == IDX_LAST) begin
               state_in = ST_LOAD;
            end
         end
         ST_LOAD: begin
            if (!scale_ff) begin
               avg_in   = avg_now;
               state_in = ST_CLAMP;
            end else begin
               div_start = 1'b1;
               state_in  = ST_WAIT;
            end
         end
         ST_WAIT: begin
            if (div_stat.done) begin
               if (!axis_ff) begin
                  last_x_in = pixel;
                  axis_in   = 1'b1;
                  scale_in  = 1'b0;
                  state_in  = ST_LOAD;
               end else begin
                  last_y_in = pixel;
                  state_in  = ST_EMIT;
               end
            end
         end
         ST_CLAMP: begin
            off_in   = (off_raw > span) ? span : off_raw;
            state_in = ST_MUL;
         end
         ST_MUL: begin
            prod_in  = {{RAW_W{1'b0}}, sel_size} * {{PIX_W{1'b0}}, off_ff};
            scale_in = 1'b1;
            state_in = ST_LOAD;
         end
         ST_EMIT: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_code_in  = pend_code_ff;
               rsp_x_in     = (pend_code_ff == EV_START) ? '0 : last_x_ff;
               rsp_y_in     = (pend_code_ff == EV_START) ? '0 : last_y_ff;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         phase_ff     <= '0;
         all_ff       <= 1'b1;
         click_ff     <= CS_NONE;
         hold_ff      <= '0;
         idx_ff       <= '0;
         last_x_ff    <= '0;
         last_y_ff    <= '0;
         k_ff         <= '0;
         axis_ff      <= 1'b0;
         scale_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         all_ff       <= all_in;
         click_ff     <= click_in;
         hold_ff      <= hold_in;
         idx_ff       <= idx_in;
         last_x_ff    <= last_x_in;
         last_y_ff    <= last_y_in;
         k_ff         <= k_in;
         axis_ff      <= axis_in;
         scale_ff     <= scale_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_code_ff <= pend_code_in;
      sum_x_ff     <= sum_x_in;
      sum_y_ff     <= sum_y_in;
      avg_ff       <= avg_in;
      off_ff       <= off_in;
      prod_ff      <= prod_in;
      rsp_code_ff  <= rsp_code_in;
      rsp_x_ff     <= rsp_x_in;
      rsp_y_ff     <= rsp_y_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_event_code = rsp_code_ff;
   assign rsp_screen_x   = rsp_x_ff;
   assign rsp_screen_y   = rsp_y_ff;

   `TGT_ASSERT_IMPLY(a_div_start_idle, div_start, !div_stat.busy,
                     "divider started while still busy")
   `TGT_ASSERT_NEXT(a_emit_loads, (state_ff == ST_EMIT) && rsp_free,
                    rsp_valid_ff && (state_ff == ST_IDLE), "pending result not loaded")
   `TGT_ASSERT_IMPLY(a_touch_held, click_ff == CS_TOUCHING, hold_ff == HOLD_SAT,
                     "touching without a saturated hold count")
   `TGT_ASSERT_IMPLY(a_idx_range, 1'b1, idx_ff <= IDX_LAST,
                     "sample index beyond the average depth")

endmodule
`default_nettype wire

>>> tb/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench of the touch gesture tracker: event predictor, scoreboard, traffic.
module tb_top;
   import tgt_pkg::*;

   // The block is built with its default gesture parameters, and the predictor
   // below uses the same values.
   localparam int TICKS_PER_CHECK   = 2;
   localparam int AVERAGE_DEPTH     = 2;
   localparam int CLICK_CHECKS      = 4;
   localparam int MAX_WAIT          = 13;
   // The slowest beat is one that finishes a position average; this is a safe
   // margin past it before the block is treated as idle.
   localparam int SETTLE_CYCLES     = 160;
   localparam int WATCHDOG_LIMIT    = 4000;
   localparam int NUM_PHASES        = 7;
   localparam int SAMPLES_PER_PHASE = 52;

   // Register indexes the block does not decode; writes to them must be dropped.
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_LO = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_HI = 3'd7;

   typedef struct {
      event_type        code;
      logic [PIX_W-1:0] x;
      logic [PIX_W-1:0] y;
   } gesture_event_type;

   // The scoreboard tracks the gesture state of the block, predicts the event
   // that each accepted sample beat causes and checks result beats in order.
   class gesture_scoreboard;
      logic [RAW_W-1:0]           cal_start_x   = CAL_START_RESET;
      logic [RAW_W-1:0]           cal_end_x     = CAL_END_RESET;
      logic [RAW_W-1:0]           cal_start_y   = CAL_START_RESET;
      logic [RAW_W-1:0]           cal_end_y     = CAL_END_RESET;
      logic [PIX_W-1:0]           screen_width  = SCREEN_W_RESET;
      logic [PIX_W-1:0]           screen_height = SCREEN_H_RESET;
      int unsigned                tick_phase    = 0;
      logic [TICKS_PER_CHECK-1:0] touch_bits    = '0;
      click_type                  gesture       = CS_NONE;
      int unsigned                hold_count    = 0;
      logic [RAW_W-1:0]           stored_x [AVERAGE_DEPTH];
      logic [RAW_W-1:0]           stored_y [AVERAGE_DEPTH];
      int unsigned                fill          = 0;
      logic [PIX_W-1:0]           last_x        = '0;
      logic [PIX_W-1:0]           last_y        = '0;
      gesture_event_type          expected_events [$];
      int unsigned                mismatches    = 0;

      function void set_register(logic [CSR_IDX_W-1:0] index, logic [CSR_DATA_W-1:0] value);
         case (index)
            CSR_CAL_START_X:   cal_start_x = value;
            CSR_CAL_END_X:     cal_end_x = value;
            CSR_CAL_START_Y:   cal_start_y = value;
            CSR_CAL_END_Y:     cal_end_y = value;
            CSR_SCREEN_WIDTH:  screen_width = value[PIX_W-1:0];
            CSR_SCREEN_HEIGHT: screen_height = value[PIX_W-1:0];
            default: ;
         endcase
      endfunction

      // Clamp to the calibration window, then scale with a truncating divide.
      function logic [PIX_W-1:0] to_pixels(int unsigned raw, int unsigned lo,
                                           int unsigned hi, int unsigned pixels);
         int unsigned span;
         int unsigned offset;
         int unsigned scaled;
         span = (hi > lo) ? hi - lo : 0;
         if (span == 0) return '0;
         offset = (raw <= lo) ? 0 : raw - lo;
         if (offset > span) offset = span;
         scaled = (pixels * offset) / span;
         return scaled[PIX_W-1:0];
      endfunction

      function void queue_event(event_type code, logic [PIX_W-1:0] x, logic [PIX_W-1:0] y);
         gesture_event_type ev;
         ev.code = code;
         ev.x = x;
         ev.y = y;
         expected_events.push_back(ev);
      endfunction

      function void note_sample(logic touched, logic [RAW_W-1:0] raw_x,
                                logic [RAW_W-1:0] raw_y, logic pos_ok);
         int unsigned sum_x;
         int unsigned sum_y;
         bit          started;
         started = 1'b0;
         touch_bits[tick_phase] = touch_bits[tick_phase] | touched;
         if (tick_phase < TICKS_PER_CHECK - 1) begin
            tick_phase++;
            return;
         end
         tick_phase = 0;
         if (&touch_bits) begin
            if (gesture == CS_NONE) begin
               gesture = CS_START;
               queue_event(EV_START, '0, '0);
               started = 1'b1;
            end
            if (hold_count < CLICK_CHECKS) begin
               hold_count++;
            end else begin
               hold_count = CLICK_CHECKS + 1;
               gesture = CS_TOUCHING;
               if (pos_ok) begin
                  stored_x[fill] = raw_x;
                  stored_y[fill] = raw_y;
                  fill++;
                  if (fill >= AVERAGE_DEPTH) begin
                     sum_x = 0;
                     sum_y = 0;
                     foreach (stored_x[k]) begin
                        sum_x += stored_x[k];
                        sum_y += stored_y[k];
                     end
                     last_x = to_pixels(sum_x / AVERAGE_DEPTH, cal_start_x, cal_end_x,
                                        screen_width);
                     last_y = to_pixels(sum_y / AVERAGE_DEPTH, cal_start_y, cal_end_y,
                                        screen_height);
                     fill = 0;
                     if (!started) queue_event(EV_TOUCHING, last_x, last_y);
                  end
               end
            end
         end else begin
            if (gesture == CS_START && hold_count <= CLICK_CHECKS) begin
               queue_event(EV_CLICK, last_x, last_y);
            end else if (gesture == CS_TOUCHING) begin
               queue_event(EV_RELEASE, last_x, last_y);
            end
            hold_count = 0;
            gesture = CS_NONE;
            fill = 0;
         end
         touch_bits = '0;
      endfunction

      function void check_event(logic [1:0] code, logic [PIX_W-1:0] x, logic [PIX_W-1:0] y);
         gesture_event_type want;
         if (expected_events.size() == 0) begin
            $error("event_code: expected no beat, actual %0d (x %0d, y %0d)", code, x, y);
            mismatches++;
            return;
         end
         want = expected_events.pop_front();
         if (code !== want.code) begin
            $error("event_code: expected %0d, actual %0d", want.code, code);
            mismatches++;
         end
         if (x !== want.x) begin
            $error("screen_x: expected %0d, actual %0d", want.x, x);
            mismatches++;
         end
         if (y !== want.y) begin
            $error("screen_y: expected %0d, actual %0d", want.y, y);
            mismatches++;
         end
      endfunction
   endclass

   // Every input has a known value from time zero; reset starts asserted.
   logic                  clock       = 1'b0;
   logic                  reset       = 1'b1;
   logic                  req_valid   = 1'b0;
   logic                  req_touched = 1'b0;
   logic [RAW_W-1:0]      req_raw_x   = '0;
   logic [RAW_W-1:0]      req_raw_y   = '0;
   logic                  req_pos_ok  = 1'b0;
   logic                  rsp_stall   = 1'b0;
   logic                  csr_we      = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index   = '0;
   logic [CSR_DATA_W-1:0] csr_wdata   = '0;
   wire logic             req_stall;
   wire logic             rsp_valid;
   wire logic [1:0]       rsp_event_code;
   wire logic [PIX_W-1:0] rsp_screen_x;
   wire logic [PIX_W-1:0] rsp_screen_y;

   // When clear, neither side inserts idle cycles, so beats go back to back.
   bit                    pace_on = 1'b1;
   int unsigned           quiet_cycles = 0;
   gesture_scoreboard     sb = new();

   touch_gesture_tracker #(
      .TICKS_PER_CHECK(TICKS_PER_CHECK),
      .AVERAGE_DEPTH  (AVERAGE_DEPTH),
      .CLICK_CHECKS   (CLICK_CHECKS)
   ) uut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_touched    (req_touched),
      .req_raw_x      (req_raw_x),
      .req_raw_y      (req_raw_y),
      .req_pos_ok     (req_pos_ok),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_event_code (rsp_event_code),
      .rsp_screen_x   (rsp_screen_x),
      .rsp_screen_y   (rsp_screen_y),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Number of idle cycles a side inserts before its next beat.
   function automatic int unsigned draw_wait();
      return pace_on ? $urandom_range(0, MAX_WAIT) : 0;
   endfunction

   // Offers one sample beat after a random gap and returns at the edge where
   // it was taken. Valid stays high across back-to-back beats.
   task automatic send_sample(logic touched, logic [RAW_W-1:0] raw_x,
                              logic [RAW_W-1:0] raw_y, logic pos_ok);
      int unsigned gap;
      gap = draw_wait();
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_touched <= touched;
      req_raw_x   <= raw_x;
      req_raw_y   <= raw_y;
      req_pos_ok  <= pos_ok;
      do @(posedge clock); while (req_stall !== 1'b0);
   endtask

   // Stops sending and waits until every predicted event has come back. With
   // full set, it also waits out the slowest computation, since a beat with no
   // event may still be in flight; this is needed before register writes.
   task automatic settle(bit full);
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.expected_events.size() != 0) @(posedge clock);
      if (full) repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(logic [CSR_IDX_W-1:0] index, logic [CSR_DATA_W-1:0] value);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      sb.set_register(index, value);
   endtask

   // Keeps a raw coordinate near a base point so that held gestures look like
   // a finger resting on the panel.
   function automatic logic [RAW_W-1:0] jitter(int base);
      int v;
      v = base + int'($urandom_range(0, 64)) - 32;
      if (v < 0) v = 0;
      if (v > 4095) v = 4095;
      return v[RAW_W-1:0];
   endfunction

   // Monitor and watchdog. Handshakes are sampled at the rising edge, before
   // any of this edge's updates land, so the order of processes does not matter.
   // Every accepted sample goes to the predictor, every accepted result beat is
   // checked against the oldest prediction.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) begin
            sb.note_sample(req_touched, req_raw_x, req_raw_y, req_pos_ok);
         end
         if (rsp_valid && !rsp_stall) begin
            sb.check_event(rsp_event_code, rsp_screen_x, rsp_screen_y);
         end
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
         end
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("status: fail");
            $finish;
         end
      end
   end

   // Result receiver: before each beat it holds stall high for a random number
   // of cycles, then takes the next beat as soon as it is offered.
   initial begin : receiver
      int unsigned hold_off;
      forever begin
         hold_off = draw_wait();
         if (hold_off != 0) begin
            rsp_stall <= 1'b1;
            repeat (hold_off) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (rsp_valid !== 1'b1);
      end
   end

   initial begin : stimulus
      int unsigned      samples;
      int unsigned      burst;
      int unsigned      checks;
      int unsigned      base_x;
      int unsigned      base_y;
      int unsigned      lo;
      bit               scatter;
      logic [RAW_W-1:0] hi;

      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed opening under the reset calibration (200..3900, 240 x 320).
      // A check where only one tick was touched is not a touch: no event.
      send_sample(1'b1, 12'h000, 12'h000, 1'b1);
      send_sample(1'b0, 12'hFFF, 12'hFFF, 1'b0);
      // A short tap: touch start, then single click. No touching event has
      // happened since reset, so the click reports position zero.
      send_sample(1'b1, 12'd100, 12'd100, 1'b1);
      send_sample(1'b1, 12'd100, 12'd100, 1'b1);
      send_sample(1'b0, 12'd100, 12'd100, 1'b1);
      send_sample(1'b0, 12'd100, 12'd100, 1'b1);
      // A held touch. The first checks only count the hold, so the positions
      // given with them are never used.
      repeat (TICKS_PER_CHECK * CLICK_CHECKS) send_sample(1'b1, 12'h800, 12'h800, 1'b0);
      // The next two checks store raw extremes: x averages above the window
      // and clamps to full width, y averages below it and clamps to zero.
      send_sample(1'b1, 12'h000, 12'hFFF, 1'b0);
      send_sample(1'b1, 12'hFFF, 12'h000, 1'b1);
      send_sample(1'b1, 12'h000, 12'hFFF, 1'b0);
      send_sample(1'b1, 12'hFFF, 12'h000, 1'b1);
      // Failed position read while touching: held, but nothing stored or sent.
      send_sample(1'b1, 12'h7FF, 12'h7FF, 1'b1);
      send_sample(1'b1, 12'h800, 12'h800, 1'b0);
      // Lifting the finger while touching gives release at the last position.
      send_sample(1'b0, 12'h555, 12'hAAA, 1'b1);
      send_sample(1'b0, 12'hAAA, 12'h555, 1'b0);

      for (int phase = 0; phase < NUM_PHASES; phase++) begin
         if (phase > 0) begin
            settle(1'b1);
            case (phase)
               1: begin
                  // Widest window and the largest screen.
                  write_reg(CSR_CAL_START_X, 12'd0);
                  write_reg(CSR_CAL_END_X, 12'd4095);
                  write_reg(CSR_CAL_START_Y, 12'd0);
                  write_reg(CSR_CAL_END_Y, 12'd4095);
                  write_reg(CSR_SCREEN_WIDTH, 12'd1023);
                  write_reg(CSR_SCREEN_HEIGHT, 12'd1023);
               end
               2: begin
                  // Empty windows (reversed on x, zero wide on y) always give
                  // pixel zero, and so does a screen height of zero. Writes to
                  // undecoded indexes must change nothing.
                  write_reg(CSR_CAL_START_X, 12'd4095);
                  write_reg(CSR_CAL_END_X, 12'd0);
                  write_reg(CSR_CAL_START_Y, 12'd2000);
                  write_reg(CSR_CAL_END_Y, 12'd2000);
                  write_reg(CSR_SCREEN_WIDTH, 12'd1);
                  write_reg(CSR_SCREEN_HEIGHT, 12'd0);
                  write_reg(CSR_SPARE_LO, 12'($urandom_range(0, 4095)));
                  write_reg(CSR_SPARE_HI, 12'($urandom_range(0, 4095)));
               end
               3: begin
                  // One-step windows in the middle and at the top of the raw range. The screen
                  // writes carry upper data bits that the 10-bit registers drop.
                  write_reg(CSR_CAL_START_X, 12'd1000);
                  write_reg(CSR_CAL_END_X, 12'd1001);
                  write_reg(CSR_CAL_START_Y, 12'd4094);
                  write_reg(CSR_CAL_END_Y, 12'd4095);
                  write_reg(CSR_SCREEN_WIDTH, 12'hFFF);
                  write_reg(CSR_SCREEN_HEIGHT, 12'hC01);
               end
               default: begin
                  // Random calibration, now and then with the ends swapped.
                  lo = $urandom_range(0, 4095);
                  hi = ($urandom_range(0, 4) == 0) ? 12'($urandom_range(0, 4095))
                                                   : 12'($urandom_range(lo, 4095));
                  write_reg(CSR_CAL_START_X, 12'(lo));
                  write_reg(CSR_CAL_END_X, hi);
                  lo = $urandom_range(0, 4095);
                  hi = ($urandom_range(0, 4) == 0) ? 12'($urandom_range(0, 4095))
                                                   : 12'($urandom_range(lo, 4095));
                  write_reg(CSR_CAL_START_Y, 12'(lo));
                  write_reg(CSR_CAL_END_Y, hi);
                  write_reg(CSR_SCREEN_WIDTH, 12'($urandom_range(0, 4095)));
                  write_reg(CSR_SCREEN_HEIGHT, 12'($urandom_range(0, 4095)));
               end
            endcase
            csr_we <= 1'b0;
         end

         // Random traffic: mostly well-formed gestures (taps, and holds of up to 14
         // checks that can produce several touching events) with random positions,
         // mixed with bursts of random samples that break the tick pairing.
         samples = 0;
         burst = 0;
         while (samples < SAMPLES_PER_PHASE) begin
            pace_on = ($urandom_range(0, 4) != 0);
            // Once per phase the sender waits until every event is back.
            if (burst == 2) settle(1'b0);
            if ($urandom_range(0, 3) != 0) begin
               checks = ($urandom_range(0, 2) == 0) ? $urandom_range(1, CLICK_CHECKS)
                                                    : $urandom_range(CLICK_CHECKS + 1, 14);
               base_x = $urandom_range(0, 4095);
               base_y = $urandom_range(0, 4095);
               scatter = ($urandom_range(0, 3) == 0);
               for (int k = 0; k < TICKS_PER_CHECK * checks; k++) begin
                  if (scatter) begin
                     send_sample(1'b1, 12'($urandom_range(0, 4095)),
                                 12'($urandom_range(0, 4095)), $urandom_range(0, 7) != 0);
                  end else begin
                     send_sample(1'b1, jitter(base_x), jitter(base_y),
                                 $urandom_range(0, 7) != 0);
                  end
                  samples++;
               end
               // Lift the finger; an odd count shifts the next gesture off
               // the tick pairing.
               repeat ($urandom_range(1, 5)) begin
                  send_sample(1'b0, 12'($urandom_range(0, 4095)),
                              12'($urandom_range(0, 4095)), $urandom_range(0, 1));
                  samples++;
               end
            end else begin
               repeat ($urandom_range(1, 6)) begin
                  send_sample($urandom_range(0, 1), 12'($urandom_range(0, 4095)),
                              12'($urandom_range(0, 4095)), $urandom_range(0, 1));
                  samples++;
               end
            end
            burst++;
         end
      end

      pace_on = 1'b1;
      settle(1'b1);
      if (sb.mismatches == 0 && sb.expected_events.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

>>> sim.f
+incdir+rtl/core
rtl/core/tgt_pkg.sv
rtl/core/tgt_divider.sv
rtl/core/touch_gesture_tracker.sv
tb/tb_top.sv
